>>> hdl/pse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg
// Types and constants shared by the protobuf scalar field encoder.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned VAL_W  = 64;
    localparam int unsigned FNUM_W = 29;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned WIRE_W = 3;
    localparam int unsigned BCNT_W = 4;

    localparam logic [WIRE_W-1:0] WIRE_VARINT = 3'd0;
    localparam logic [WIRE_W-1:0] WIRE_BITS64 = 3'd1;
    localparam logic [WIRE_W-1:0] WIRE_BITS32 = 3'd5;

    localparam logic [BCNT_W-1:0] FIX4_BYTES = 4'd4;
    localparam logic [BCNT_W-1:0] FIX8_BYTES = 4'd8;

    typedef enum logic [OP_W-1:0] {
        OP_VARINT  = 3'd0,
        OP_ZIGZAG  = 3'd1,
        OP_FIXED32 = 3'd2,
        OP_FLOAT32 = 3'd3,
        OP_FIXED64 = 3'd4,
        OP_FLOAT64 = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        MODE_VARINT = 2'd0,
        MODE_FIX4   = 2'd1,
        MODE_FIX8   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_KEY  = 2'd1,
        PH_VAL  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        t_mode            mode;
    } t_entry;

endpackage
`default_nettype wire

>>> hdl/pse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_front
// Decode one field: build the key, prepare the value word and its form,
// and drop fields that are skipped or carry an unused operation.
// ----------------------------------------------------------------------------
module pse_front
    import pse_pkg::*;
(
    input  wire logic              i_accept,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [FNUM_W-1:0] i_fnum,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic              i_skip_if_zero,
    output logic                   o_push,
    output t_entry                 o_entry
);

    logic              known;
    logic              zero;
    logic [WIRE_W-1:0] key_wire;
    logic [VAL_W-1:0]  word;
    t_mode             mode;

    always_comb begin
        known    = 1'b1;
        zero     = (i_value == '0);
        key_wire = WIRE_VARINT;
        word     = i_value;
        mode     = MODE_VARINT;
        case (i_operation)
            OP_VARINT: begin
                key_wire = WIRE_VARINT;
            end
            OP_ZIGZAG: begin
                word = {i_value[VAL_W-2:0], 1'b0} ^ {VAL_W{i_value[VAL_W-1]}};
            end
            OP_FIXED32: begin
                key_wire = WIRE_BITS32;
                zero     = (i_value[31:0] == '0);
                word     = {32'd0, i_value[31:0]};
                mode     = MODE_FIX4;
            end
            OP_FLOAT32: begin
                key_wire = WIRE_BITS32;
                zero     = (i_value[30:0] == '0);
                word     = {32'd0, i_value[31:0]};
                mode     = MODE_FIX4;
            end
            OP_FIXED64: begin
                key_wire = WIRE_BITS64;
                mode     = MODE_FIX8;
            end
            OP_FLOAT64: begin
                key_wire = WIRE_BITS64;
                zero     = (i_value[VAL_W-2:0] == '0);
                mode     = MODE_FIX8;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    assign o_push        = i_accept && known && !(i_skip_if_zero && zero);
    assign o_entry.key   = {i_fnum, key_wire};
    assign o_entry.value = word;
    assign o_entry.mode  = mode;

endmodule
`default_nettype wire

>>> hdl/pse_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_queue
// Small first-in first-out buffer of decoded fields between front and back.
// ----------------------------------------------------------------------------
module pse_queue
    import pse_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_entry      o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hdl/pse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pse_back
// Serialize one decoded field per queue entry: key varint, then value as
// varint or little-endian bytes into an output register, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module pse_back
    import pse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_head_valid,
    input  wire t_entry     i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    t_phase              r_phase;
    t_phase              n_phase;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_val;
    t_mode               r_mode;
    logic [BCNT_W-1:0]   r_cnt;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic                adv;
    logic                step;
    logic [KEY_W-1:0]    key_src;
    logic                key_more;
    logic                val_more;
    logic [7:0]          byte_nx;
    logic                last_nx;

    assign adv      = !r_out_valid || i_ready;
    assign key_src  = (r_phase == PH_IDLE) ? i_head.key : r_key;
    assign key_more = (key_src[KEY_W-1:7] != '0);
    assign val_more = (r_val[VAL_W-1:7] != '0);

    always_comb begin
        step    = 1'b0;
        o_pop   = 1'b0;
        byte_nx = {key_more, key_src[6:0]};
        last_nx = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                step  = adv && i_head_valid;
                o_pop = adv && i_head_valid;
            end
            PH_KEY: begin
                step = adv;
            end
            PH_VAL: begin
                step = adv;
                if (r_mode == MODE_VARINT) begin
                    byte_nx = {val_more, r_val[6:0]};
                    last_nx = !val_more;
                end else begin
                    byte_nx = r_val[7:0];
                    last_nx = (r_cnt == BCNT_W'(1));
                end
            end
            default: begin
                step = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (step) begin
            case (r_phase)
                PH_IDLE, PH_KEY: n_phase = key_more ? PH_KEY : PH_VAL;
                PH_VAL:          n_phase = last_nx ? PH_IDLE : PH_VAL;
                default:         n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= byte_nx;
            r_out_last <= last_nx;
        end
        if (step && r_phase != PH_VAL) begin
            r_key <= {7'd0, key_src[KEY_W-1:7]};
        end
        if (o_pop) begin
            r_val  <= i_head.value;
            r_mode <= i_head.mode;
            r_cnt  <= (i_head.mode == MODE_FIX4) ? FIX4_BYTES : FIX8_BYTES;
        end else if (step && r_phase == PH_VAL) begin
            if (r_mode == MODE_VARINT) begin
                r_val <= {7'd0, r_val[VAL_W-1:7]};
            end else begin
                r_val <= {8'd0, r_val[VAL_W-1:8]};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule
`default_nettype wire

>>> hdl/protobuf_scalar_field_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// protobuf_scalar_field_encoder
// Encode one scalar protobuf field per input item into key and value bytes.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                     | tuser                  | tlast
//  s_axis   | in  | fnum[28:0] value[92:29]   | operation[2:0] skip[3] | -
//  m_axis   | out | out_byte[7:0]             | -                      | last
//
//  One output byte per cycle while m_axis is not stalled; a field is 2 to 15
//  bytes (key plus value bytes), set by the byte serializer in the back end.
//  Skipped fields and unused operations produce no bytes and no output cycle.
//  An input item is taken every cycle while the decoded-field queue has room.
//  Synchronous reset clears the queue, serializer state and output valid.
//  A stall on m_axis holds the output register; the queue absorbs input.
// ----------------------------------------------------------------------------
module protobuf_scalar_field_encoder
    import pse_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // fnum, value, zero pad
    input  wire logic [3:0]  s_axis_tuser,  // operation, skip_if_zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // out_byte
    output logic             m_axis_tlast   // last
);

    logic   full;
    logic   push;
    logic   pop;
    logic   head_valid;
    t_entry entry;
    t_entry head;

    assign s_axis_tready = !full;

    pse_front u_front (
        .i_accept       (s_axis_tvalid && s_axis_tready),
        .i_operation    (s_axis_tuser[2:0]),
        .i_fnum         (s_axis_tdata[28:0]),
        .i_value        (s_axis_tdata[92:29]),
        .i_skip_if_zero (s_axis_tuser[3]),
        .o_push         (push),
        .o_entry        (entry)
    );

    pse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    pse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule
`default_nettype wire
